// ===== rtl/core/mpd_pkg.sv =====
// Shared types, codes and constants of the multichannel pulse detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

    // Parameter defaults
    localparam int CHANNELS_DEF    = 4;
    localparam int COUNT_WIDTH_DEF = 24;

    // Field widths
    localparam int CH_W     = 2;
    localparam int SAMPLE_W = 10;
    localparam int SPEED_W  = 12;
    localparam int STATUS_W = 3;
    localparam int PERIOD_W = 24;
    localparam int UNIT_W   = 10;
    localparam int DEB_W    = 8;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Limit scaling: long limit is unit * LONG_FACTOR / s,
    // warning limits are unit * WARN_FACTOR / (3 * s)
    localparam int LONG_FACTOR = 100 * 20;
    localparam int WARN_FACTOR = 100 * 5;
    localparam int LIM_W       = UNIT_W + $clog2(LONG_FACTOR);

    // Second multiplier operand holds up to three times the speed
    localparam int MUL_B_W = SPEED_W + 2;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    // Channel phase
    typedef logic [1:0] t_phase;
    localparam t_phase PH_IDLE   = 2'd0;
    localparam t_phase PH_START  = 2'd1;
    localparam t_phase PH_STABLE = 2'd2;
    localparam t_phase PH_END    = 2'd3;

    // Result status
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_NONE      = 3'd0;
    localparam t_status ST_PULSE     = 3'd1;
    localparam t_status ST_MISS_LOW  = 3'd2;
    localparam t_status ST_MISS_HIGH = 3'd3;
    localparam t_status ST_UNSTABLE  = 3'd4;
    localparam t_status ST_HIGH_LONG = 3'd5;
    localparam t_status ST_LOW_LONG  = 3'd6;

    // Commands
    typedef logic t_cmd;
    localparam t_cmd CMD_TICK  = 1'b0;
    localparam t_cmd CMD_CLEAR = 1'b1;

    // Register map (word index)
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_LEVEL     = 3'd0;
    localparam t_reg_idx REG_HIGH_DEB  = 3'd1;
    localparam t_reg_idx REG_LOW_DEB   = 3'd2;
    localparam t_reg_idx REG_LOW_UNIT  = 3'd3;
    localparam t_reg_idx REG_HIGH_UNIT = 3'd4;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] RST_LEVEL     = 10'd512;
    localparam logic [DEB_W-1:0]    RST_HIGH_DEB  = 8'd3;
    localparam logic [DEB_W-1:0]    RST_LOW_DEB   = 8'd3;
    localparam logic [UNIT_W-1:0]   RST_LOW_UNIT  = 10'd10;
    localparam logic [UNIT_W-1:0]   RST_HIGH_UNIT = 10'd10;

endpackage

`default_nettype wire

// ===== rtl/core/mpd_mul_unit.sv =====
// Shared multiplier of the pulse detector with a registered product.
// Depends on mpd_pkg for the width of the second operand.
`timescale 1ns / 1ps
`default_nettype none

module mpd_mul_unit #(
    parameter int A_W = mpd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic [A_W-1:0]                    i_a,
    input  wire logic [mpd_pkg::MUL_B_W-1:0]       i_b,
    output logic      [A_W+mpd_pkg::MUL_B_W-1:0]   o_prod
);
    import mpd_pkg::*;

    logic [A_W+MUL_B_W-1:0] r_prod;

    // Multiply and register
    always_ff @(posedge i_clk) begin
        r_prod <= (A_W+MUL_B_W)'(i_a) * (A_W+MUL_B_W)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/core/multichannel_pulse_detector.sv =====
// Multichannel pulse detector: each transaction passes through idle, six sequencer
// steps (five products through the shared multiplier and a final compare) and a write-back;
// the result then waits in an output register. A new transaction is accepted only in idle,
// after the previous one has been written back, as the shared multiplier sequence serves
// one transaction at a time; a result left waiting holds the write-back step and the input.
// Synchronous reset clears every channel as a clear command and restores the registers.
// Depends on mpd_pkg and mpd_mul_unit.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_pulse_detector #(
    parameter int CHANNELS    = mpd_pkg::CHANNELS_DEF,
    parameter int COUNT_WIDTH = mpd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // APB-style configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mpd_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [mpd_pkg::DATA_W-1:0]      pwdata,
    output logic      [mpd_pkg::DATA_W-1:0]      prdata,
    output logic                                 pready,
    // Input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_cmd,
    input  wire logic [mpd_pkg::CH_W-1:0]        i_channel,
    input  wire logic [mpd_pkg::SAMPLE_W-1:0]    i_sample,
    input  wire logic [mpd_pkg::SPEED_W-1:0]     i_speed_coeff,
    // Output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [mpd_pkg::STATUS_W-1:0]    o_status,
    output logic                                 o_period_valid,
    output logic      [mpd_pkg::PERIOD_W-1:0]    o_period,
    output logic      [mpd_pkg::CH_W-1:0]        o_out_channel
);
    import mpd_pkg::*;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W   = COUNT_WIDTH + MUL_B_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_PMAX = COUNT_WIDTH'(PERIOD_MAX);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [2:0] STEP_LAST = 3'd5;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // Configuration registers
    logic [SAMPLE_W-1:0] r_level;
    logic [DEB_W-1:0]    r_high_deb;
    logic [DEB_W-1:0]    r_low_deb;
    logic [UNIT_W-1:0]   r_low_unit;
    logic [UNIT_W-1:0]   r_high_unit;

    // Per-channel state
    t_phase                 r_phase  [CHANNELS];
    logic [COUNT_WIDTH-1:0] r_hrun   [CHANNELS];
    logic [COUNT_WIDTH-1:0] r_lrun   [CHANNELS];
    logic [COUNT_WIDTH-1:0] r_per    [CHANNELS];
    logic [COUNT_WIDTH-1:0] r_idle   [CHANNELS];
    logic                   r_first  [CHANNELS];

    // Sequencer and working registers
    logic [1:0]           r_state, n_state;
    logic [2:0]           r_step;
    t_cmd                 r_cmd;
    logic [CH_W-1:0]      r_ch;
    logic                 r_ch_ok;
    logic [CH_IDX_W-1:0]  r_idx;
    logic                 r_high;
    logic [SPEED_W-1:0]   r_s;
    logic [MUL_B_W-1:0]   r_s3;
    logic [LIM_W-1:0]     r_lim_long;
    logic [LIM_W-1:0]     r_lim_warn;
    logic                 r_gt_long;
    logic                 r_gt_warn;
    logic                 r_gt_unst;

    // Output register
    logic                 r_out_valid;
    t_status              r_status;
    logic                 r_pvalid;
    logic [PERIOD_W-1:0]  r_period;
    logic [CH_W-1:0]      r_out_ch;

    logic                 cfg_wr;
    logic                 in_acc;
    logic                 can_push;
    logic                 ch_ok_in;
    logic [SPEED_W-1:0]   s_clamped;

    // Channel view and next values
    t_phase                 cur_ph;
    logic [COUNT_WIDTH-1:0] cur_hrun, cur_lrun, cur_idle;
    logic                   cur_first;
    logic [COUNT_WIDTH-1:0] per_inc, hrun_inc, lrun_inc, idle_inc;
    logic [COUNT_WIDTH-1:0] cnt_op;
    logic [UNIT_W-1:0]      warn_unit;
    t_phase                 n_ph;
    logic [COUNT_WIDTH-1:0] n_hrun, n_lrun, n_per, n_idle;
    logic                   n_first;
    t_status                n_status;
    logic                   n_pvalid;
    logic [PERIOD_W-1:0]    n_period;

    // Multiplier operands
    logic [COUNT_WIDTH-1:0] mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [PROD_W-1:0]      prod;

    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc    = i_in_valid && o_in_ready;
    assign can_push  = !r_out_valid || i_out_ready;
    assign ch_ok_in  = (32'(i_channel) < 32'(CHANNELS));
    assign s_clamped = (i_speed_coeff == '0) ? SPEED_W'(1) : i_speed_coeff;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= RST_LEVEL;
            r_high_deb  <= RST_HIGH_DEB;
            r_low_deb   <= RST_LOW_DEB;
            r_low_unit  <= RST_LOW_UNIT;
            r_high_unit <= RST_HIGH_UNIT;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_LEVEL:     r_level     <= pwdata[SAMPLE_W-1:0];
                REG_HIGH_DEB:  r_high_deb  <= pwdata[DEB_W-1:0];
                REG_LOW_DEB:   r_low_deb   <= pwdata[DEB_W-1:0];
                REG_LOW_UNIT:  r_low_unit  <= pwdata[UNIT_W-1:0];
                REG_HIGH_UNIT: r_high_unit <= pwdata[UNIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (paddr[4:2])
            REG_LEVEL:     prdata = DATA_W'(r_level);
            REG_HIGH_DEB:  prdata = DATA_W'(r_high_deb);
            REG_LOW_DEB:   prdata = DATA_W'(r_low_deb);
            REG_LOW_UNIT:  prdata = DATA_W'(r_low_unit);
            REG_HIGH_UNIT: prdata = DATA_W'(r_high_unit);
            default:       prdata = '0;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_RUN;
            S_RUN:  if (r_step == STEP_LAST) n_state = S_DONE;
            S_DONE: if (can_push) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RUN) begin
                r_step <= r_step + 3'd1;
            end else begin
                r_step <= '0;
            end
        end
    end

    // Latch the transaction
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_cmd;
            r_ch    <= i_channel;
            r_ch_ok <= ch_ok_in;
            r_idx   <= ch_ok_in ? CH_IDX_W'(i_channel) : '0;
            r_high  <= (i_sample > r_level);
            r_s     <= s_clamped;
            r_s3    <= MUL_B_W'(s_clamped) + {1'b0, s_clamped, 1'b0};
        end
    end

    // Current state of the addressed channel and its incremented counters
    always_comb begin
        cur_ph    = r_phase[r_idx];
        cur_hrun  = r_hrun[r_idx];
        cur_lrun  = r_lrun[r_idx];
        cur_idle  = r_idle[r_idx];
        cur_first = r_first[r_idx];
        per_inc   = sat_inc(r_per[r_idx]);
        hrun_inc  = sat_inc(cur_hrun);
        lrun_inc  = sat_inc(cur_lrun);
        idle_inc  = sat_inc(cur_idle);
        // idle runs are checked in idle, high runs in stable high
        cnt_op    = (cur_ph == PH_IDLE) ? idle_inc : hrun_inc;
        warn_unit = (cur_ph == PH_IDLE) ? r_low_unit : r_high_unit;
    end

    // Operand select: two limits, then three count products
    always_comb begin
        case (r_step)
            3'd0: begin
                mul_a = COUNT_WIDTH'(r_low_unit);
                mul_b = MUL_B_W'(LONG_FACTOR);
            end
            3'd1: begin
                mul_a = COUNT_WIDTH'(warn_unit);
                mul_b = MUL_B_W'(WARN_FACTOR);
            end
            3'd2: begin
                mul_a = cnt_op;
                mul_b = MUL_B_W'(r_s);
            end
            3'd3: begin
                mul_a = cnt_op;
                mul_b = r_s3;
            end
            3'd4: begin
                mul_a = per_inc;
                mul_b = MUL_B_W'(r_s);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mpd_mul_unit #(
        .A_W (COUNT_WIDTH)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Capture limits and compare results; count > floor(A / d) holds exactly when
    // count * d > A
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN) begin
            case (r_step)
                3'd1: r_lim_long <= prod[LIM_W-1:0];
                3'd2: r_lim_warn <= prod[LIM_W-1:0];
                3'd3: r_gt_long  <= (prod > PROD_W'(r_lim_long));
                3'd4: r_gt_warn  <= (prod > PROD_W'(r_lim_warn));
                3'd5: r_gt_unst  <= (prod > PROD_W'(r_lim_long));
                default: ;
            endcase
        end
    end

    // Next channel state and result
    always_comb begin
        n_ph     = cur_ph;
        n_hrun   = cur_hrun;
        n_lrun   = cur_lrun;
        n_per    = per_inc;
        n_idle   = cur_idle;
        n_first  = cur_first;
        n_status = r_gt_unst ? ST_UNSTABLE : ST_NONE;
        n_pvalid = 1'b0;
        n_period = '0;

        if (r_cmd == CMD_CLEAR) begin
            n_ph     = PH_IDLE;
            n_hrun   = '0;
            n_lrun   = '0;
            n_per    = '0;
            n_idle   = '0;
            n_first  = 1'b1;
            n_status = ST_NONE;
        end else begin
            unique case (cur_ph)
                PH_IDLE: begin
                    if (r_high) begin
                        n_ph   = PH_START;
                        n_hrun = COUNT_WIDTH'(1);
                        n_lrun = '0;
                    end else begin
                        n_idle = idle_inc;
                        if (r_gt_long) begin
                            n_status = ST_MISS_LOW;
                        end else if (r_gt_warn) begin
                            n_status = ST_LOW_LONG;
                        end
                    end
                end
                PH_START: begin
                    n_idle = '0;
                    if (r_high) begin
                        n_hrun = hrun_inc;
                        if (hrun_inc >= COUNT_WIDTH'(r_high_deb)) n_ph = PH_STABLE;
                    end else begin
                        n_ph = PH_IDLE;
                    end
                end
                PH_STABLE: begin
                    if (!r_high) begin
                        n_ph   = PH_END;
                        n_lrun = COUNT_WIDTH'(1);
                        n_hrun = '0;
                    end else begin
                        n_hrun = hrun_inc;
                        if (r_gt_long) begin
                            n_status = ST_MISS_HIGH;
                        end else if (r_gt_warn) begin
                            n_status = ST_HIGH_LONG;
                        end
                    end
                end
                PH_END: begin
                    if (!r_high) begin
                        n_lrun = lrun_inc;
                        if (lrun_inc >= COUNT_WIDTH'(r_low_deb)) begin
                            // pulse accepted: report period unless first after clear
                            n_ph     = PH_IDLE;
                            n_status = ST_PULSE;
                            n_per    = '0;
                            n_first  = 1'b0;
                            if (!cur_first) begin
                                n_pvalid = 1'b1;
                                n_period = (per_inc > CNT_PMAX) ? PERIOD_MAX
                                                                : PERIOD_W'(per_inc);
                            end
                        end
                    end else begin
                        n_ph = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end

        // Drop everything for a channel that does not exist
        if (!r_ch_ok) begin
            n_status = ST_NONE;
            n_pvalid = 1'b0;
            n_period = '0;
        end
    end

    // Write back channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_phase[i] <= PH_IDLE;
                r_hrun[i]  <= '0;
                r_lrun[i]  <= '0;
                r_per[i]   <= '0;
                r_idle[i]  <= '0;
                r_first[i] <= 1'b1;
            end
        end else if (r_state == S_DONE && can_push && r_ch_ok) begin
            r_phase[r_idx] <= n_ph;
            r_hrun[r_idx]  <= n_hrun;
            r_lrun[r_idx]  <= n_lrun;
            r_per[r_idx]   <= n_per;
            r_idle[r_idx]  <= n_idle;
            r_first[r_idx] <= n_first;
        end
    end

    // Output register: load on completion, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && can_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && can_push) begin
            r_status <= n_status;
            r_pvalid <= n_pvalid;
            r_period <= n_period;
            r_out_ch <= r_ch;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_period_valid = r_pvalid;
    assign o_period       = r_period;
    assign o_out_channel  = r_out_ch;

endmodule

`default_nettype wire

// ===== tb/sv/tb_multichannel_pulse_detector.sv =====
// Self-checking testbench for the multichannel pulse detector: directed and random
// sample ticks, per-channel prediction, APB register set-up and output back-pressure.
// Depends on mpd_pkg and the multichannel_pulse_detector RTL.
`timescale 1ns / 1ps

module tb_multichannel_pulse_detector;

    import mpd_pkg::*;

    localparam int unsigned WARN_DIV = 3;
    localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_TOP = '1;

    typedef struct packed {
        t_cmd                cmd;
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] sample;
        logic [SPEED_W-1:0]  speed_coeff;
    } t_pd_item;

    typedef struct packed {
        t_status             status;
        logic                period_valid;
        logic [PERIOD_W-1:0] period;
        logic [CH_W-1:0]     out_channel;
    } t_pd_result;

    // DUT connections
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_cmd;
    logic [CH_W-1:0]     i_channel;
    logic [SAMPLE_W-1:0] i_sample;
    logic [SPEED_W-1:0]  i_speed_coeff;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic                o_period_valid;
    logic [PERIOD_W-1:0] o_period;
    logic [CH_W-1:0]     o_out_channel;

    // Detector register copy
    logic [SAMPLE_W-1:0] cfg_level;
    logic [DEB_W-1:0]    cfg_high_deb;
    logic [DEB_W-1:0]    cfg_low_deb;
    logic [UNIT_W-1:0]   cfg_low_unit;
    logic [UNIT_W-1:0]   cfg_high_unit;

    // Per-channel detector state copy
    t_phase                     ch_phase    [CHANNELS_DEF];
    logic [COUNT_WIDTH_DEF-1:0] ch_high_run [CHANNELS_DEF];
    logic [COUNT_WIDTH_DEF-1:0] ch_low_run  [CHANNELS_DEF];
    logic [COUNT_WIDTH_DEF-1:0] ch_period   [CHANNELS_DEF];
    logic [COUNT_WIDTH_DEF-1:0] ch_idle     [CHANNELS_DEF];
    logic                       ch_unmeasured [CHANNELS_DEF];

    t_pd_result  pending_results[$];
    t_pd_result  due;
    int unsigned error_count = 0;
    logic        idling_on;
    int unsigned stall_request;

    multichannel_pulse_detector i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_channel      (i_channel),
        .i_sample       (i_sample),
        .i_speed_coeff  (i_speed_coeff),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_period_valid (o_period_valid),
        .o_period       (o_period),
        .o_out_channel  (o_out_channel)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    //--------------------------------------------------------------------------
    // Detector prediction
    //--------------------------------------------------------------------------

    function automatic logic [COUNT_WIDTH_DEF-1:0] sat_inc(input logic [COUNT_WIDTH_DEF-1:0] v);
        return (v == COUNT_TOP) ? v : v + 1'b1;
    endfunction

    function automatic void clear_channel(input logic [CH_W-1:0] c);
        ch_phase[c]      = PH_IDLE;
        ch_high_run[c]   = '0;
        ch_low_run[c]    = '0;
        ch_period[c]     = '0;
        ch_idle[c]       = '0;
        ch_unmeasured[c] = 1'b1;
    endfunction

    function automatic void reset_detector_copy();
        cfg_level     = RST_LEVEL;
        cfg_high_deb  = RST_HIGH_DEB;
        cfg_low_deb   = RST_LOW_DEB;
        cfg_low_unit  = RST_LOW_UNIT;
        cfg_high_unit = RST_HIGH_UNIT;
        for (int c = 0; c < CHANNELS_DEF; c++) begin
            clear_channel(c[CH_W-1:0]);
        end
    endfunction

    // Walk one channel's phase machine for one transaction and form its result
    function automatic t_pd_result predict_result(input t_pd_item it);
        t_pd_result      res;
        logic [CH_W-1:0] c;
        int unsigned     s;
        int unsigned     unit_lo;
        int unsigned     unit_hi;
        int unsigned     lim_long;
        int unsigned     lim_low;
        int unsigned     lim_high;
        logic            is_high;
        c = it.channel;
        res.status       = ST_NONE;
        res.period_valid = 1'b0;
        res.period       = '0;
        res.out_channel  = c;
        if (it.cmd == CMD_CLEAR) begin
            clear_channel(c);
            return res;
        end
        // Speed coefficient below one counts as one
        s = (it.speed_coeff == '0) ? 1 : 32'(it.speed_coeff);
        unit_lo  = 32'(cfg_low_unit);
        unit_hi  = 32'(cfg_high_unit);
        lim_long = unit_lo * LONG_FACTOR / s;
        lim_low  = unit_lo * WARN_FACTOR / (WARN_DIV * s);
        lim_high = unit_hi * WARN_FACTOR / (WARN_DIV * s);
        is_high  = it.sample > cfg_level;
        ch_period[c] = sat_inc(ch_period[c]);
        case (ch_phase[c])
            PH_IDLE: begin
                if (is_high) begin
                    ch_phase[c]    = PH_START;
                    ch_high_run[c] = COUNT_WIDTH_DEF'(1);
                    ch_low_run[c]  = '0;
                end else begin
                    ch_idle[c] = sat_inc(ch_idle[c]);
                    if (ch_idle[c] > lim_long) begin
                        res.status = ST_MISS_LOW;
                        return res;
                    end
                    if (ch_idle[c] > lim_low) begin
                        res.status = ST_LOW_LONG;
                        return res;
                    end
                end
            end
            PH_START: begin
                ch_idle[c] = '0;
                if (is_high) begin
                    ch_high_run[c] = sat_inc(ch_high_run[c]);
                    if (ch_high_run[c] >= cfg_high_deb) ch_phase[c] = PH_STABLE;
                end else begin
                    ch_phase[c] = PH_IDLE;
                end
            end
            PH_STABLE: begin
                if (!is_high) begin
                    ch_phase[c]    = PH_END;
                    ch_low_run[c]  = COUNT_WIDTH_DEF'(1);
                    ch_high_run[c] = '0;
                end else begin
                    ch_high_run[c] = sat_inc(ch_high_run[c]);
                    if (ch_high_run[c] > lim_long) begin
                        res.status = ST_MISS_HIGH;
                        return res;
                    end
                    if (ch_high_run[c] > lim_high) begin
                        res.status = ST_HIGH_LONG;
                        return res;
                    end
                end
            end
            default: begin
                if (!is_high) begin
                    ch_low_run[c] = sat_inc(ch_low_run[c]);
                    if (ch_low_run[c] >= cfg_low_deb) begin
                        ch_phase[c] = PH_IDLE;
                        // First pulse after a clear carries no period
                        if (ch_unmeasured[c]) begin
                            ch_unmeasured[c] = 1'b0;
                        end else begin
                            res.period_valid = 1'b1;
                            res.period       = ch_period[c];
                        end
                        ch_period[c] = '0;
                        res.status   = ST_PULSE;
                        return res;
                    end
                end else begin
                    ch_phase[c] = PH_IDLE;
                end
            end
        endcase
        if (ch_period[c] > lim_long) res.status = ST_UNSTABLE;
        return res;
    endfunction

    //--------------------------------------------------------------------------
    // Result checking
    //--------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result on channel %0d with nothing pending", o_out_channel);
                error_count++;
            end else begin
                due = pending_results.pop_front();
                if (o_status !== due.status) begin
                    $error("status: expected %0d, actual %0d", due.status, o_status);
                    error_count++;
                end
                if (o_period_valid !== due.period_valid) begin
                    $error("period_valid: expected %0d, actual %0d",
                           due.period_valid, o_period_valid);
                    error_count++;
                end
                if (o_period !== due.period) begin
                    $error("period: expected %0d, actual %0d", due.period, o_period);
                    error_count++;
                end
                if (o_out_channel !== due.out_channel) begin
                    $error("out_channel: expected %0d, actual %0d",
                           due.out_channel, o_out_channel);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    initial begin : result_receiver
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_request != 0) begin
                i_out_ready   = 1'b0;
                stall_left    = stall_request - 1;
                stall_request = 0;
            end else if (stall_left != 0) begin
                stall_left--;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                stall_left  = $urandom_range(0, 7);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    //--------------------------------------------------------------------------
    // Configuration port
    //--------------------------------------------------------------------------

    task automatic write_register(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_LEVEL:     cfg_level     = value[SAMPLE_W-1:0];
            REG_HIGH_DEB:  cfg_high_deb  = value[DEB_W-1:0];
            REG_LOW_DEB:   cfg_low_deb   = value[DEB_W-1:0];
            REG_LOW_UNIT:  cfg_low_unit  = value[UNIT_W-1:0];
            REG_HIGH_UNIT: cfg_high_unit = value[UNIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_register(input t_reg_idx idx, input logic [DATA_W-1:0] want);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $error("register %0d: expected %0d, actual %0d", idx, want, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Write every register, then read each one back
    task automatic apply_config(input logic [SAMPLE_W-1:0] level, input logic [DEB_W-1:0] hd,
                                input logic [DEB_W-1:0] ls, input logic [UNIT_W-1:0] lu,
                                input logic [UNIT_W-1:0] hu);
        write_register(REG_LEVEL, DATA_W'(level));
        write_register(REG_HIGH_DEB, DATA_W'(hd));
        write_register(REG_LOW_DEB, DATA_W'(ls));
        write_register(REG_LOW_UNIT, DATA_W'(lu));
        write_register(REG_HIGH_UNIT, DATA_W'(hu));
        check_register(REG_LEVEL, DATA_W'(cfg_level));
        check_register(REG_HIGH_DEB, DATA_W'(cfg_high_deb));
        check_register(REG_LOW_DEB, DATA_W'(cfg_low_deb));
        check_register(REG_LOW_UNIT, DATA_W'(cfg_low_unit));
        check_register(REG_HIGH_UNIT, DATA_W'(cfg_high_unit));
    endtask

    //--------------------------------------------------------------------------
    // Sample transactions
    //--------------------------------------------------------------------------

    // Offer one transaction, hold it until accepted, queue its expected result
    task automatic send_item(input t_pd_item it);
        int unsigned gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_cmd         = it.cmd;
        i_channel     = it.channel;
        i_sample      = it.sample;
        i_speed_coeff = it.speed_coeff;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        pending_results.push_back(predict_result(it));
        @(negedge i_clk);
    endtask

    // Drop valid and let every outstanding result drain
    task automatic wait_for_results();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    function automatic t_pd_item make_tick(input logic [CH_W-1:0] ch,
                                           input logic [SAMPLE_W-1:0] level,
                                           input logic [SPEED_W-1:0] speed);
        t_pd_item it;
        it.cmd         = CMD_TICK;
        it.channel     = ch;
        it.sample      = level;
        it.speed_coeff = speed;
        return it;
    endfunction

    function automatic logic [SAMPLE_W-1:0] high_level_sample();
        if (cfg_level == '1) return '1;
        return SAMPLE_W'($urandom_range(32'(cfg_level) + 1, 1023));
    endfunction

    function automatic logic [SAMPLE_W-1:0] low_level_sample();
        return SAMPLE_W'($urandom_range(0, 32'(cfg_level)));
    endfunction

    function automatic logic [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 3))
            0:       return SPEED_W'($urandom());
            1:       return SPEED_W'($urandom_range(0, 3));
            default: return SPEED_W'($urandom_range(1, 64));
        endcase
    endfunction

    task automatic send_noise();
        t_pd_item it;
        it.cmd         = ($urandom_range(0, 11) == 0) ? CMD_CLEAR : CMD_TICK;
        it.channel     = CH_W'($urandom());
        it.sample      = SAMPLE_W'($urandom());
        it.speed_coeff = SPEED_W'($urandom());
        send_item(it);
    endtask

    task automatic send_run(input logic [CH_W-1:0] ch, input logic [SPEED_W-1:0] speed,
                            input logic [SAMPLE_W-1:0] level, input int unsigned count);
        repeat (count) send_item(make_tick(ch, level, speed));
    endtask

    // Mostly debounced high/low trains on one channel, some cut short, some noise between
    task automatic run_pulse_trains(input int unsigned n_items);
        int unsigned      sent;
        int unsigned      highs;
        int unsigned      lows;
        logic [CH_W-1:0]  ch;
        logic [SPEED_W-1:0] speed;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                send_noise();
                sent++;
            end else begin
                ch    = CH_W'($urandom());
                speed = pick_speed();
                highs = ((cfg_high_deb < 2) ? 2 : 32'(cfg_high_deb)) + $urandom_range(0, 2);
                lows  = ((cfg_low_deb < 2) ? 2 : 32'(cfg_low_deb)) + $urandom_range(0, 2);
                if ($urandom_range(0, 5) == 0) highs = $urandom_range(1, highs - 1);
                if ($urandom_range(0, 5) == 0) lows = $urandom_range(1, lows - 1);
                for (int unsigned k = 0; k < highs + lows; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_noise();
                        sent++;
                    end
                    send_item(make_tick(ch, (k < highs) ? high_level_sample()
                                                        : low_level_sample(), speed));
                    sent++;
                end
            end
        end
    endtask

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------

    task automatic test_register_reset_values();
        check_register(REG_LEVEL, DATA_W'(RST_LEVEL));
        check_register(REG_HIGH_DEB, DATA_W'(RST_HIGH_DEB));
        check_register(REG_LOW_DEB, DATA_W'(RST_LOW_DEB));
        check_register(REG_LOW_UNIT, DATA_W'(RST_LOW_UNIT));
        check_register(REG_HIGH_UNIT, DATA_W'(RST_HIGH_UNIT));
    endtask

    task automatic test_directed_sequences();
        t_pd_item it;
        // Unmeasured first pulse, then a measured one; 512 sits on the threshold
        send_run(2'd0, 12'd1, 10'd1023, 4);
        send_run(2'd0, 12'd1, 10'd512, 3);
        send_run(2'd0, 12'd1, 10'd513, 3);
        send_run(2'd0, 12'd1, 10'd0, 3);
        // Fastest speed: high too long, then missing high, then unstable on the falling edge
        send_run(2'd2, 12'd4095, 10'd1023, 5);
        send_run(2'd2, 12'd4095, 10'd0, 1);
        // Low too long, then missing low
        send_run(2'd3, 12'd4095, 10'd0, 5);
        // Speed zero with an aborted start
        send_run(2'd1, 12'd0, 10'd1023, 1);
        send_run(2'd1, 12'd0, 10'd0, 1);
        // Clear commands with extreme payloads, then a fresh unmeasured pulse start
        it = make_tick(2'd0, 10'd1023, 12'd4095);
        it.cmd = CMD_CLEAR;
        send_item(it);
        it = make_tick(2'd3, 10'd0, 12'd0);
        it.cmd = CMD_CLEAR;
        send_item(it);
        send_run(2'd3, 12'd2048, 10'd700, 1);
        wait_for_results();
    endtask

    task automatic test_default_trains();
        run_pulse_trains(300);
        wait_for_results();
    endtask

    task automatic test_wide_open_limits();
        apply_config(10'd0, 8'd1, 8'd1, 10'd1023, 10'd0);
        run_pulse_trains(150);
        wait_for_results();
    endtask

    // Nothing exceeds the top threshold and every limit is zero
    task automatic test_zero_limits();
        apply_config(10'd1023, 8'd255, 8'd255, 10'd0, 10'd0);
        repeat (60) send_noise();
        wait_for_results();
    endtask

    task automatic test_zero_debounce();
        apply_config(SAMPLE_W'($urandom_range(200, 800)), 8'd0, 8'd0, UNIT_W'($urandom()),
                     UNIT_W'($urandom()));
        run_pulse_trains(150);
        wait_for_results();
    endtask

    // Hold the output off long enough for the detector to stall its input
    task automatic test_output_backpressure();
        apply_config(RST_LEVEL, RST_HIGH_DEB, RST_LOW_DEB, RST_LOW_UNIT, RST_HIGH_UNIT);
        idling_on     = 1'b0;
        stall_request = 300;
        run_pulse_trains(40);
        wait_for_results();
        idling_on = 1'b1;
    endtask

    task automatic test_steady_stream();
        idling_on = 1'b0;
        apply_config(SAMPLE_W'($urandom()), DEB_W'($urandom_range(1, 6)),
                     DEB_W'($urandom_range(1, 6)), UNIT_W'($urandom()), UNIT_W'($urandom()));
        run_pulse_trains(150);
        wait_for_results();
    endtask

    //--------------------------------------------------------------------------
    // Sequence
    //--------------------------------------------------------------------------

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_TICK;
        i_channel     = '0;
        i_sample      = '0;
        i_speed_coeff = '0;
        i_out_ready   = 1'b0;
        idling_on     = 1'b1;
        stall_request = 0;
        reset_detector_copy();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_reset_values();
        test_directed_sequences();
        test_default_trains();
        test_wide_open_limits();
        test_zero_limits();
        test_zero_debounce();
        test_output_backpressure();
        test_steady_stream();

        repeat (16) @(negedge i_clk);
        if (error_count == 0) begin
            $display("multichannel_pulse_detector verification clean");
        end else begin
            $display("multichannel_pulse_detector verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("multichannel_pulse_detector verification failed");
        $finish;
    end

endmodule
